@@ rtl/wp_pkg.sv @@
// Types, constants and round functions for the Whirlpool compression block.
// Depends on nothing; used by whirlpool_compression.
package wp_pkg;

    localparam int ROUNDS = 10;
    localparam int RND_W  = $clog2(ROUNDS + 1);

    typedef logic [7:0][63:0] t_block;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY,
        ST_DATA,
        ST_FIN,
        ST_OUT
    } t_state;

    localparam logic [15:0][3:0] EBOX = {
        4'h0, 4'h5, 4'h2, 4'ha, 4'h4, 4'h7, 4'h8, 4'he,
        4'h3, 4'hf, 4'h6, 4'hd, 4'hc, 4'h9, 4'hb, 4'h1};
    localparam logic [15:0][3:0] EINV = {
        4'h6, 4'h8, 4'h4, 4'h3, 4'h1, 4'hc, 4'h2, 4'h9,
        4'ha, 4'h5, 4'he, 4'hb, 4'h7, 4'hd, 4'h0, 4'hf};
    localparam logic [15:0][3:0] RBOX = {
        4'h0, 4'h1, 4'h5, 4'h2, 4'ha, 4'h8, 4'h3, 4'h6,
        4'hf, 4'h9, 4'h4, 4'he, 4'hd, 4'hb, 4'hc, 4'h7};
    localparam logic [7:0][7:0] CIRC = {
        8'd9, 8'd2, 8'd5, 8'd8, 8'd1, 8'd4, 8'd1, 8'd1};

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [3:0] a, b, r;
        a = EBOX[x[7:4]];
        b = EINV[x[3:0]];
        r = RBOX[a ^ b];
        return {EBOX[a ^ r], EINV[b ^ r]};
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] c);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (c[i]) p = p ^ x;
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1d) : {x[6:0], 1'b0};
        end
        return p;
    endfunction

    function automatic t_block round_fn(input t_block s, input t_block k);
        logic [7:0] t [8][8];
        logic [7:0] acc;
        t_block     o;
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                t[i][j] = sub_byte(s[(i - j + 8) % 8][63 - 8 * j -: 8]);
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++) begin
                acc = '0;
                for (int n = 0; n < 8; n++)
                    acc = acc ^ gf_mul(t[i][n], CIRC[(j - n + 8) % 8]);
                o[i][63 - 8 * j -: 8] = acc ^ k[i][63 - 8 * j -: 8];
            end
        return o;
    endfunction

    function automatic t_block round_const(input logic [RND_W-1:0] r);
        t_block     c;
        logic [7:0] base;
        c    = '0;
        base = 8'({r - RND_W'(1), 3'b000});
        for (int j = 0; j < 8; j++)
            c[0][63 - 8 * j -: 8] = sub_byte(base + 8'(j));
        return c;
    endfunction

endpackage

@@ rtl/whirlpool_compression.sv @@
// Whirlpool-512 compression with Miyaguchi-Preneel chaining and digest output.
// Depends on wp_pkg (types, S-box, round function).
//
// A block of eight 64-bit words is taken one word per transfer. After the
// eighth word the block is busy and takes no input: one shared round
// unit computes the key schedule round and the data round alternately, then
// the chaining value is updated in the ST_FIN state. If the block was marked
// final, the eight digest words follow, one per output transfer; no input is
// taken until the last digest word has gone out.
module whirlpool_compression
    import wp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_message_word,
    input  logic        i_start_of_message,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic        o_last_word
);

    t_state            r_state, n_state;
    t_block            r_chain, n_chain;
    t_block            r_buf, n_buf;
    t_block            r_cst, n_cst;
    t_block            r_key, n_key;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_end, n_end;
    logic [RND_W-1:0]  r_rnd, n_rnd;
    logic [2:0]        r_oidx, n_oidx;

    t_block            w_rin, w_radd, w_rout, w_buf, w_chain;
    logic              w_in_xfer;

    assign w_in_xfer = i_valid && o_ready;
    assign o_ready   = (r_state == ST_LOAD);
    assign o_valid   = (r_state == ST_OUT);
    assign o_digest_word = r_chain[r_oidx];
    assign o_last_word   = (r_oidx == 3'd7);

    assign w_rin  = (r_state == ST_KEY) ? r_key : r_cst;
    assign w_radd = (r_state == ST_KEY) ? round_const(r_rnd) : r_key;
    assign w_rout = round_fn(w_rin, w_radd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_chain <= '0;
            r_cnt   <= '0;
            r_end   <= 1'b0;
            r_rnd   <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_chain <= n_chain;
            r_cnt   <= n_cnt;
            r_end   <= n_end;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
        end
        r_buf <= n_buf;
        r_cst <= n_cst;
        r_key <= n_key;
    end

    always_comb begin
        n_state = r_state;
        n_chain = r_chain;
        n_buf   = r_buf;
        n_cst   = r_cst;
        n_key   = r_key;
        n_cnt   = r_cnt;
        n_end   = r_end;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        w_buf   = r_buf;
        w_buf[r_cnt] = i_message_word;
        w_chain = i_start_of_message ? '0 : r_chain;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_xfer) begin
                    n_chain = w_chain;
                    n_buf   = w_buf;
                    n_end   = r_end | i_end_of_message;
                    n_cnt   = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_key   = w_chain;
                        n_cst   = w_buf ^ w_chain;
                        n_rnd   = RND_W'(1);
                        n_state = ST_KEY;
                    end
                end
            end
            ST_KEY: begin
                n_key   = w_rout;
                n_state = ST_DATA;
            end
            ST_DATA: begin
                n_cst = w_rout;
                if (r_rnd == RND_W'(ROUNDS)) begin
                    n_state = ST_FIN;
                end else begin
                    n_rnd   = r_rnd + RND_W'(1);
                    n_state = ST_KEY;
                end
            end
            ST_FIN: begin
                n_chain = r_chain ^ r_cst ^ r_buf;
                n_end   = 1'b0;
                n_oidx  = '0;
                n_state = r_end ? ST_OUT : ST_LOAD;
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input and output open together");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KEY || r_state == ST_DATA) |->
        (r_rnd >= RND_W'(1) && r_rnd <= RND_W'(ROUNDS)))
        else $error("round count out of range");

    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && r_cnt == 3'd7) |=> (r_state == ST_KEY && r_cnt == 3'd0))
        else $error("full block did not start cipher");

    a_out_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> o_ready)
        else $error("did not return to load after last digest word");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for whirlpool_compression: random message words in,
// digest words checked against an in-bench Whirlpool compression predictor.
// Depends on wp_pkg and the whirlpool_compression RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wp_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic        som;
        logic        eom;
    } t_msg_item;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } t_digest_item;

    localparam logic [7:0][7:0] MIX_ROW = {8'd9, 8'd2, 8'd5, 8'd8, 8'd1, 8'd4, 8'd1, 8'd1};
    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_message_word;
    logic        i_start_of_message;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_digest_word;
    logic        o_last_word;

    whirlpool_compression dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_message_word     (i_message_word),
        .i_start_of_message (i_start_of_message),
        .i_end_of_message   (i_end_of_message),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_digest_word      (o_digest_word),
        .o_last_word        (o_last_word)
    );

    t_msg_item    pending_words[$];
    t_digest_item digest_expected[$];
    int           error_count;
    int           cycle_count;
    bit           stim_done;

    logic [63:0] hash_chain[8];
    logic [63:0] load_buf[8];
    int          load_idx;
    bit          final_seen;

    function automatic logic [7:0] wp_sbox(input logic [7:0] x);
        logic [3:0] e_tab[16];
        logic [3:0] ei_tab[16];
        logic [3:0] r_tab[16];
        logic [3:0] a, b, r;
        e_tab  = '{4'h1, 4'hb, 4'h9, 4'hc, 4'hd, 4'h6, 4'hf, 4'h3,
                   4'he, 4'h8, 4'h7, 4'h4, 4'ha, 4'h2, 4'h5, 4'h0};
        ei_tab = '{4'hf, 4'h0, 4'hd, 4'h7, 4'hb, 4'he, 4'h5, 4'ha,
                   4'h9, 4'h2, 4'hc, 4'h1, 4'h3, 4'h4, 4'h8, 4'h6};
        r_tab  = '{4'h7, 4'hc, 4'hb, 4'hd, 4'he, 4'h4, 4'h9, 4'hf,
                   4'h6, 4'h3, 4'h8, 4'ha, 4'h2, 4'h5, 4'h1, 4'h0};
        a = e_tab[x[7:4]];
        b = ei_tab[x[3:0]];
        r = r_tab[a ^ b];
        return {e_tab[a ^ r], ei_tab[b ^ r]};
    endfunction

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] c);
        logic [8:0] x;
        logic [7:0] p;
        p = '0;
        x = {1'b0, a};
        for (int i = 0; i < 8; i++) begin
            if (c[i]) p = p ^ x[7:0];
            x = x << 1;
            if (x[8]) x = x ^ 9'h11d;
        end
        return p;
    endfunction

    function automatic t_block wp_round(input t_block s, input t_block k);
        logic [7:0] t[8][8];
        logic [7:0] acc;
        t_block     o;
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                t[i][j] = wp_sbox(s[(i - j + 8) % 8][63 - 8 * j -: 8]);
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++) begin
                acc = '0;
                for (int n = 0; n < 8; n++)
                    acc = acc ^ gf_times(t[i][n], MIX_ROW[(j - n + 8) % 8]);
                o[i][63 - 8 * j -: 8] = acc ^ k[i][63 - 8 * j -: 8];
            end
        return o;
    endfunction

    task automatic compress_block();
        t_block key, st, rc;
        for (int i = 0; i < 8; i++) begin
            key[i] = hash_chain[i];
            st[i]  = load_buf[i] ^ hash_chain[i];
        end
        for (int r = 1; r <= ROUNDS; r++) begin
            rc = '0;
            for (int j = 0; j < 8; j++)
                rc[0][63 - 8 * j -: 8] = wp_sbox(8'(8 * (r - 1) + j));
            key = wp_round(key, rc);
            st  = wp_round(st, key);
        end
        for (int i = 0; i < 8; i++)
            hash_chain[i] = hash_chain[i] ^ st[i] ^ load_buf[i];
    endtask

    task automatic predict_word(input t_msg_item m);
        t_digest_item d;
        if (m.som) begin
            for (int i = 0; i < 8; i++) hash_chain[i] = '0;
        end
        if (m.eom) final_seen = 1'b1;
        load_buf[load_idx] = m.word;
        if (load_idx != 7) begin
            load_idx++;
            return;
        end
        load_idx = 0;
        compress_block();
        if (!final_seen) return;
        final_seen = 1'b0;
        for (int k = 0; k < 8; k++) begin
            d.word = hash_chain[k];
            d.last = (k == 7);
            digest_expected.push_back(d);
        end
    endtask

    task automatic queue_word(input logic [63:0] w, input bit som, input bit eom);
        t_msg_item m;
        m.word = w;
        m.som  = som;
        m.eom  = eom;
        pending_words.push_back(m);
    endtask

    task automatic queue_message(input int blocks, input bit som);
        for (int b = 0; b < blocks; b++)
            for (int w = 0; w < 8; w++)
                queue_word({$urandom, $urandom}, som && b == 0 && w == 0,
                           b == blocks - 1 && w == $urandom_range(7, 0));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: bursts and gaps.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid            <= 1'b0;
            i_message_word     <= '0;
            i_start_of_message <= 1'b0;
            i_end_of_message   <= 1'b0;
            burst_left         <= 0;
            gap_left           <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) predict_word(pending_words.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_valid            <= 1'b1;
                i_message_word     <= pending_words[0].word;
                i_start_of_message <= pending_words[0].som;
                i_end_of_message   <= pending_words[0].eom;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern plus one long hold-off.
    int stall_phase;
    int hold_count;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready     <= 1'b0;
            stall_phase <= 0;
            hold_count  <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_count < 600 && cycle_count > 300) begin
                hold_count <= hold_count + 1;
                i_ready    <= 1'b0;
            end else if ((stall_phase / 64) % 3 == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(3, 0) != 0);
            end
        end
    end

    // Monitor.
    t_digest_item exp_d;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_expected.size() == 0) begin
                $error("digest_word: unexpected transfer, actual %h", o_digest_word);
                error_count++;
            end else begin
                exp_d = digest_expected.pop_front();
                if (o_digest_word !== exp_d.word) begin
                    $error("digest_word: expected %h actual %h", exp_d.word, o_digest_word);
                    error_count++;
                end
                if (o_last_word !== exp_d.last) begin
                    $error("last_word: expected %b actual %b", exp_d.last, o_last_word);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        stim_done   = 1'b0;
        load_idx    = 0;
        final_seen  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            hash_chain[i] = '0;
            load_buf[i]   = '0;
        end
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All-zero and all-ones single-block messages.
        for (int w = 0; w < 8; w++) queue_word('0, w == 0, w == 7);
        for (int w = 0; w < 8; w++) queue_word('1, w == 0, w == 0);
        // Two blocks, the second with a start mark in mid-block and several end marks.
        for (int w = 0; w < 8; w++) queue_word(64'h0123456789abcdef << w, w == 0, 1'b0);
        for (int w = 0; w < 8; w++) queue_word({$urandom, $urandom}, w == 3, w[0]);
        // Continue from the digest without a start mark.
        for (int w = 0; w < 8; w++) queue_word({$urandom, $urandom}, 1'b0, w == 5);

        while (pending_words.size() + 5 * 8 < 190) begin
            case ($urandom_range(9, 0))
                0: queue_message(1, 1'b0);
                1: queue_word({$urandom, $urandom}, $urandom_range(1, 0), $urandom_range(1, 0));
                default: queue_message($urandom_range(2, 1), 1'b1);
            endcase
        end
        // Fill up the last block so every word gets used.
        while ((pending_words.size() + 40) % 8 != 0)
            queue_word({$urandom, $urandom}, 1'b0, 1'b1);

        wait (pending_words.size() == 0 && !i_valid);
        wait (digest_expected.size() == 0);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
